// ----- src/kvs_pkg.sv -----
// Package for the keyed Vigenere stream cipher: payload structs, register
// indexes, character constants and the alphabet lookup helpers.
// No dependencies.
package kvs_pkg;

  localparam int unsigned LETTERS         = 26;
  localparam int unsigned CODE_W          = 5;
  localparam int unsigned ALPHA_W         = LETTERS * CODE_W;   // 130
  localparam int unsigned MAX_KEY_LETTERS = 12;
  localparam int unsigned KEY_W           = MAX_KEY_LETTERS * CODE_W;
  localparam int unsigned CFG_DATA_W      = 60;

  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ALPHA_LOW = 3'd0,
    CFG_ALPHA_MID = 3'd1,
    CFG_ALPHA_TOP = 3'd2,
    CFG_KEY_LET   = 3'd3,
    CFG_KEY_LEN   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
    logic       first;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       not_found;
  } out_t;

  typedef struct packed {
    logic       found;
    logic [4:0] pos;
  } pos_t;

  // whitespace: tab through carriage return, and space
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // lowest alphabet index whose entry equals code
  function automatic pos_t find_pos(input logic [ALPHA_W-1:0] alpha,
                                    input logic [CODE_W-1:0]  code);
    pos_t res;
    res = '{found: 1'b0, pos: '0};
    for (int j = LETTERS - 1; j >= 0; j--) begin
      if (alpha[j*CODE_W +: CODE_W] == code) begin
        res.found = 1'b1;
        res.pos   = 5'(j);
      end
    end
    return res;
  endfunction

  // alphabet entry at idx (idx below LETTERS)
  function automatic logic [CODE_W-1:0] entry_at(input logic [ALPHA_W-1:0] alpha,
                                                 input logic [4:0]         idx);
    logic [CODE_W-1:0] e;
    e = '1;
    for (int j = 0; j < LETTERS; j++) begin
      if (idx == 5'(j)) e = alpha[j*CODE_W +: CODE_W];
    end
    return e;
  endfunction

endpackage

// ----- src/keyed_vigenere_stream_top.sv -----
// Top level of the keyed Vigenere stream cipher: config registers, key
// counter, input stage and result register.
// Depends on kvs_pkg.
//
// Keyed Vigenere stream cipher, one ASCII byte per transaction. Lowercase
// letters are encrypted (mode 0) or decrypted (mode 1) over a configurable
// 26-entry keyed alphabet with a repeating key of 1 to 12 letters; whitespace
// passes unchanged and uses no key letter; first restarts the key. Anything
// missing from the alphabet gives not_found with char_out 0. One byte is
// accepted per clock unless out_stall holds a full pipeline. Two register
// stages: the input stage takes the key letter on acceptance, then the
// alphabet search, mod-26 add and entry select load the result register
// once free. The user writes configuration only while no transaction is
// in flight; the block does not enforce it. cfg_ready is always high.
module keyed_vigenere_stream_top
  import kvs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [ALPHA_W-1:0] alpha_r;
  logic [KEY_W-1:0]   key_letters_r;
  logic [3:0]         key_length_r;

  // key counter
  logic [3:0] key_pos_r, key_pos_nxt;

  // input stage
  logic              s1_valid_r;
  logic              s1_mode_r;
  logic [7:0]        s1_char_r;
  logic [CODE_W-1:0] s1_kcode_r;

  // result register
  logic out_valid_r;
  out_t out_data_r;

  logic advance, in_accept;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r       <= '0;
      key_letters_r <= '0;
      key_length_r  <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ALPHA_LOW: alpha_r[59:0]    <= cfg_data;
        CFG_ALPHA_MID: alpha_r[119:60]  <= cfg_data;
        CFG_ALPHA_TOP: alpha_r[129:120] <= cfg_data[9:0];
        CFG_KEY_LET:   key_letters_r    <= cfg_data[KEY_W-1:0];
        CFG_KEY_LEN:   key_length_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // key letter selection and next key position
  logic [3:0]        key_len_eff, kp_base, kp_use;
  logic [4:0]        kp_inc;
  logic [CODE_W-1:0] kcode;

  always_comb begin
    if (key_length_r == 4'd0)                       key_len_eff = 4'd1;
    else if (key_length_r > 4'(MAX_KEY_LETTERS))    key_len_eff = 4'(MAX_KEY_LETTERS);
    else                                            key_len_eff = key_length_r;
    kp_base = in_data.first ? 4'd0 : key_pos_r;
    kp_use  = (kp_base < key_len_eff) ? kp_base : 4'd0;
    kcode   = key_letters_r[6'(kp_use) * 6'd5 +: CODE_W];
    kp_inc  = 5'(kp_use) + 5'd1;
    key_pos_nxt = key_pos_r;
    if (in_accept) begin
      if (is_ws(in_data.char_in)) key_pos_nxt = kp_base;
      else if (kp_inc >= 5'(key_len_eff)) key_pos_nxt = 4'd0;
      else key_pos_nxt = kp_inc[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) key_pos_r <= 4'd0;
    else        key_pos_r <= key_pos_nxt;
  end

  // input stage: loads whenever it is empty or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode_r  <= in_data.mode;
      s1_char_r  <= in_data.char_in;
      s1_kcode_r <= kcode;
    end
  end

  // alphabet search, mod-26 step and entry lookup
  pos_t       pp, pk;
  logic       is_lower;
  logic [5:0] sum;
  logic [4:0] idx;
  logic [4:0] r;
  out_t       res;

  always_comb begin
    is_lower = (s1_char_r >= CHAR_LOWER_A) && (s1_char_r <= CHAR_LOWER_Z);
    pp  = find_pos(alpha_r, 5'(s1_char_r - CHAR_LOWER_A));
    pk  = find_pos(alpha_r, s1_kcode_r);
    if (s1_mode_r) begin
      if (pp.pos >= pk.pos) sum = 6'(pp.pos) - 6'(pk.pos);
      else                  sum = 6'(pp.pos) + 6'(LETTERS) - 6'(pk.pos);
    end else begin
      sum = 6'(pp.pos) + 6'(pk.pos);
      if (sum >= 6'(LETTERS)) sum = sum - 6'(LETTERS);
    end
    idx = sum[4:0];
    r   = entry_at(alpha_r, idx);
    res = '{char_out: 8'd0, not_found: 1'b1};
    if (is_ws(s1_char_r)) begin
      res = '{char_out: s1_char_r, not_found: 1'b0};
    end else if (is_lower && pp.found && pk.found && (r < 5'(LETTERS))) begin
      res = '{char_out: CHAR_LOWER_A + 8'(r), not_found: 1'b0};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) out_data_r <= res;
  end

  // checks
  a_key_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    key_pos_r < 4'(MAX_KEY_LETTERS))
    else $error("key position out of range");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.not_found) |-> (out_data_r.char_out == 8'd0))
    else $error("not_found result with nonzero byte");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("input stage item lost");

endmodule
